@@ src/fcc_pkg.sv @@
// Shared types and constants for the frustum cull classifier.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fcc_pkg;

  // Fixed field widths of the stream payload
  localparam int FIELD_W     = 32;
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 3;
  localparam int CLS_W       = 2;
  localparam int IN_TDATA_W  = 232;  // 3 + 7*32 = 227 bits, padded to whole bytes
  localparam int OUT_TDATA_W = 8;

  // Bit positions of the input tdata fields
  localparam int IDX_LSB  = 0;
  localparam int X_LSB    = 3;
  localparam int Y_LSB    = 35;
  localparam int Z_LSB    = 67;
  localparam int W_LSB    = 99;
  localparam int MAXX_LSB = 131;
  localparam int MAXY_LSB = 163;
  localparam int MAXZ_LSB = 195;

  // Product terms per plane: three for one distance, six for a box (two corners)
  localparam int          TERM_W           = 3;
  localparam logic [2:0]  TERM_LAST_SIMPLE = 3'd2;
  localparam logic [2:0]  TERM_LAST_BOX    = 3'd5;
  localparam logic [2:0]  TERM_NEG_FIRST   = 3'd3;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_SPHERE = 2'd2,
    CMD_BOX    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CLS_INSIDE    = 2'd0,
    CLS_INTERSECT = 2'd1,
    CLS_OUTSIDE   = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MUL   = 2'd1,
    ST_DRAIN = 2'd2,
    ST_EVAL  = 2'd3
  } fcc_state_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic init;   // load both accumulators with the scaled plane offset
    logic issue;  // start one product this cycle
    logic neg;    // product belongs to the negative-corner accumulator
  } mac_ctrl_t;

endpackage

`default_nettype wire

@@ src/fcc_plane_file.sv @@
// Plane register file: normal and offset per plane, cleared to zero by reset.
// One write port for loads, one read port addressed by the sequencer. Uses fcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcc_plane_file
  import fcc_pkg::*;
#(
  parameter int PLANE_COUNT = 6,
  parameter int OPW         = 32,
  parameter int PIDX_W      = 3
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [PIDX_W-1:0]        wr_idx,
  input  wire logic signed [OPW-1:0]    wr_nx,
  input  wire logic signed [OPW-1:0]    wr_ny,
  input  wire logic signed [OPW-1:0]    wr_nz,
  input  wire logic signed [OPW-1:0]    wr_off,
  input  wire logic [PIDX_W-1:0]        rd_idx,
  output logic signed [OPW-1:0]         rd_nx,
  output logic signed [OPW-1:0]         rd_ny,
  output logic signed [OPW-1:0]         rd_nz,
  output logic signed [OPW-1:0]         rd_off
);

  logic signed [OPW-1:0] nx_r  [PLANE_COUNT];
  logic signed [OPW-1:0] ny_r  [PLANE_COUNT];
  logic signed [OPW-1:0] nz_r  [PLANE_COUNT];
  logic signed [OPW-1:0] off_r [PLANE_COUNT];

  // Write one plane per load; reset gives all-zero planes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        nx_r[i]  <= '0;
        ny_r[i]  <= '0;
        nz_r[i]  <= '0;
        off_r[i] <= '0;
      end
    end else if (wr_en) begin
      nx_r[wr_idx]  <= wr_nx;
      ny_r[wr_idx]  <= wr_ny;
      nz_r[wr_idx]  <= wr_nz;
      off_r[wr_idx] <= wr_off;
    end
  end

  assign rd_nx  = nx_r[rd_idx];
  assign rd_ny  = ny_r[rd_idx];
  assign rd_nz  = nz_r[rd_idx];
  assign rd_off = off_r[rd_idx];

endmodule

`default_nettype wire

@@ src/fcc_mac.sv @@
// Shared multiply-accumulate unit: one registered product per cycle, added in the
// next cycle into the positive- or negative-corner accumulator. Uses fcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcc_mac
  import fcc_pkg::*;
#(
  parameter int OPW       = 32,
  parameter int FRAC_BITS = 16,
  parameter int ACC_W     = 67
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mac_ctrl_t                ctrl,
  input  wire logic signed [OPW-1:0]    op_a,
  input  wire logic signed [OPW-1:0]    op_b,
  input  wire logic signed [OPW-1:0]    plane_off,
  output logic signed [ACC_W-1:0]       acc_p,
  output logic signed [ACC_W-1:0]       acc_n
);

  logic signed [2*OPW-1:0]  prod_r;
  logic                     prod_v_r;
  logic                     prod_neg_r;
  logic signed [ACC_W-1:0]  acc_p_r;
  logic signed [ACC_W-1:0]  acc_n_r;
  logic signed [ACC_W-1:0]  off_scaled;
  logic signed [ACC_W-1:0]  prod_ext;

  // offset carries FRAC_BITS fraction bits; products carry twice that
  assign off_scaled = ACC_W'(plane_off) <<< FRAC_BITS;
  assign prod_ext   = ACC_W'(prod_r);

  // Product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= op_a * op_b;
    prod_neg_r <= ctrl.neg;
  end

  // Accumulate stage; init never coincides with a pending product
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      acc_p_r <= off_scaled;
      acc_n_r <= off_scaled;
    end else if (prod_v_r) begin
      if (prod_neg_r) begin
        acc_n_r <= acc_n_r + prod_ext;
      end else begin
        acc_p_r <= acc_p_r + prod_ext;
      end
    end
  end

  assign acc_p = acc_p_r;
  assign acc_n = acc_n_r;

endmodule

`default_nettype wire

@@ src/frustum_cull_classifier.sv @@
// Frustum cull classifier: a load gives no result. A query runs plane by plane
// through one shared multiplier: per plane 3 products (point, sphere) or 6 (box),
// then a drain state and a compare state; the query ends early on an outside
// verdict. Input ready only when the sequencer is idle. Reset (rst_n, synchronous)
// clears all planes to zero and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module frustum_cull_classifier
  import fcc_pkg::*;
#(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // tdata from bit 0: plane_index[3], x[32], y[32], z[32], w[32],
  // max_x[32], max_y[32], max_z[32], zero pad[5]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: command[2]
  input  wire logic [CMD_W-1:0]       in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // tdata from bit 0: classification[2], zero pad[6]
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  // Inputs are 32-bit fields, so values never need more than 32 bits
  localparam int OPW    = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int BASE_W = (2*OPW > OPW + FRAC_BITS) ? 2*OPW : OPW + FRAC_BITS;
  localparam int ACC_W  = BASE_W + 3;
  localparam int PIDX_W = $clog2(PLANE_COUNT);
  localparam logic [PIDX_W-1:0] PLANE_LAST = PIDX_W'(PLANE_COUNT - 1);

  // Input field views
  logic [IDX_W-1:0]       in_idx;
  logic signed [OPW-1:0]  in_x, in_y, in_z, in_w, in_mx, in_my, in_mz;
  cmd_t                   in_cmd;

  assign in_idx = in_tdata[IDX_LSB +: IDX_W];
  assign in_x   = in_tdata[X_LSB +: OPW];
  assign in_y   = in_tdata[Y_LSB +: OPW];
  assign in_z   = in_tdata[Z_LSB +: OPW];
  assign in_w   = in_tdata[W_LSB +: OPW];
  assign in_mx  = in_tdata[MAXX_LSB +: OPW];
  assign in_my  = in_tdata[MAXY_LSB +: OPW];
  assign in_mz  = in_tdata[MAXZ_LSB +: OPW];
  assign in_cmd = cmd_t'(in_tuser);

  // Sequencer state and query operands
  fcc_state_t             state_r, state_nxt;
  cmd_t                   cmd_r;
  logic [PIDX_W-1:0]      plane_r, plane_nxt;
  logic [TERM_W-1:0]      term_r, term_nxt;
  cls_t                   res_r, res_nxt;
  logic signed [OPW-1:0]  qx_r, qy_r, qz_r, qw_r, qmx_r, qmy_r, qmz_r;
  logic                   out_valid_r, out_valid_nxt;
  cls_t                   out_cls_r, out_cls_nxt;

  logic                   in_fire;
  logic                   plane_we;
  mac_ctrl_t              mac_ctrl;
  logic signed [OPW-1:0]  pl_nx, pl_ny, pl_nz, pl_off;
  logic signed [OPW-1:0]  op_a, op_b;
  logic signed [ACC_W-1:0] acc_p, acc_n;
  logic signed [ACC_W-1:0] rad_scaled;
  logic signed [ACC_W-1:0] sph_far, sph_near;
  logic                   pos_x, pos_y, pos_z;
  logic                   is_box;
  logic [TERM_W-1:0]      term_last;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign plane_we  = in_fire && (in_cmd == CMD_LOAD) && (int'(in_idx) < PLANE_COUNT);

  fcc_plane_file #(
    .PLANE_COUNT (PLANE_COUNT),
    .OPW         (OPW),
    .PIDX_W      (PIDX_W)
  ) u_planes (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (plane_we),
    .wr_idx (in_idx[PIDX_W-1:0]),
    .wr_nx  (in_x),
    .wr_ny  (in_y),
    .wr_nz  (in_z),
    .wr_off (in_w),
    .rd_idx (plane_r),
    .rd_nx  (pl_nx),
    .rd_ny  (pl_ny),
    .rd_nz  (pl_nz),
    .rd_off (pl_off)
  );

  fcc_mac #(
    .OPW       (OPW),
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mac_ctrl),
    .op_a      (op_a),
    .op_b      (op_b),
    .plane_off (pl_off),
    .acc_p     (acc_p),
    .acc_n     (acc_n)
  );

  // Corner selection: positive normal component picks the max for the positive corner
  assign pos_x     = (pl_nx != '0) && !pl_nx[OPW-1];
  assign pos_y     = (pl_ny != '0) && !pl_ny[OPW-1];
  assign pos_z     = (pl_nz != '0) && !pl_nz[OPW-1];
  assign is_box    = (cmd_r == CMD_BOX);
  assign term_last = is_box ? TERM_LAST_BOX : TERM_LAST_SIMPLE;

  // Operand mux for the shared multiplier
  always_comb begin
    op_a = pl_nx;
    op_b = qx_r;
    case (term_r)
      3'd0: begin
        op_a = pl_nx;
        op_b = (is_box && pos_x) ? qmx_r : qx_r;
      end
      3'd1: begin
        op_a = pl_ny;
        op_b = (is_box && pos_y) ? qmy_r : qy_r;
      end
      3'd2: begin
        op_a = pl_nz;
        op_b = (is_box && pos_z) ? qmz_r : qz_r;
      end
      3'd3: begin
        op_a = pl_nx;
        op_b = pos_x ? qx_r : qmx_r;
      end
      3'd4: begin
        op_a = pl_ny;
        op_b = pos_y ? qy_r : qmy_r;
      end
      3'd5: begin
        op_a = pl_nz;
        op_b = pos_z ? qz_r : qmz_r;
      end
      default: begin
        op_a = pl_nx;
        op_b = qx_r;
      end
    endcase
  end

  // Sphere bounds: distance plus and minus the scaled radius
  assign rad_scaled = ACC_W'(qw_r) <<< FRAC_BITS;
  assign sph_far    = acc_p + rad_scaled;
  assign sph_near   = acc_p - rad_scaled;

  // Next state, MAC control and per-plane verdict
  always_comb begin
    logic finish;
    logic outside;
    logic hit;
    cls_t verdict;

    state_nxt     = state_r;
    plane_nxt     = plane_r;
    term_nxt      = term_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_cls_nxt   = out_cls_r;
    mac_ctrl      = '0;
    finish        = 1'b0;
    outside       = 1'b0;
    hit           = 1'b0;
    verdict       = res_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_cmd != CMD_LOAD)) begin
          state_nxt = ST_MUL;
          plane_nxt = '0;
          term_nxt  = '0;
          res_nxt   = CLS_INSIDE;
        end
      end
      ST_MUL: begin
        mac_ctrl.issue = 1'b1;
        mac_ctrl.init  = (term_r == '0);
        mac_ctrl.neg   = (term_r >= TERM_NEG_FIRST);
        if (term_r == term_last) begin
          term_nxt  = '0;
          state_nxt = ST_DRAIN;
        end else begin
          term_nxt = term_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        case (cmd_r)
          CMD_SPHERE: begin
            outside = sph_far[ACC_W-1];
            hit     = sph_near[ACC_W-1];
          end
          CMD_BOX: begin
            outside = acc_p[ACC_W-1];
            hit     = acc_n[ACC_W-1];
          end
          default: begin
            outside = acc_p[ACC_W-1];
            hit     = 1'b0;
          end
        endcase
        if (outside) begin
          verdict = CLS_OUTSIDE;
        end else if (hit) begin
          verdict = CLS_INTERSECT;
        end
        finish = outside || (plane_r == PLANE_LAST);
        if (!finish) begin
          res_nxt   = verdict;
          plane_nxt = plane_r + 1'b1;
          state_nxt = ST_MUL;
        end else if (!out_valid_r || out_tready) begin
          // result goes out only once the output register is free
          out_valid_nxt = 1'b1;
          out_cls_nxt   = verdict;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      plane_r     <= '0;
      term_r      <= '0;
      res_r       <= CLS_INSIDE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plane_r     <= plane_nxt;
      term_r      <= term_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Query capture and result payload
  always_ff @(posedge clk) begin
    out_cls_r <= out_cls_nxt;
    if (in_fire) begin
      cmd_r <= in_cmd;
      qx_r  <= in_x;
      qy_r  <= in_y;
      qz_r  <= in_z;
      qw_r  <= in_w;
      qmx_r <= in_mx;
      qmy_r <= in_my;
      qmz_r <= in_mz;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - CLS_W){1'b0}}, out_cls_r};

  // A query transaction starts the product sequence on the next cycle
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser != CMD_LOAD)) |=> (state_r == ST_MUL && term_r == '0))
    else $error("query accepted but sequencer did not start");

  // The plane counter never walks past the last plane
  a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (plane_r <= PLANE_LAST))
    else $error("plane counter out of range");

  // A load transaction never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_LOAD) && !out_tvalid) |=> !out_tvalid)
    else $error("load produced a result");

  // Output code is always a valid classification
  a_cls_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3))
    else $error("invalid classification code");

endmodule

`default_nettype wire

@@ tb/frustum_cull_classifier_tb.sv @@
// Self-checking testbench for frustum_cull_classifier: directed table plus random
// plane loads and point, sphere and box queries, checked against a local predictor.
// Depends on fcc_pkg and the frustum_cull_classifier RTL.
`timescale 1ns / 1ps

module frustum_cull_classifier_tb;
  import fcc_pkg::*;

  localparam int PLANES       = 6;
  localparam int COORD_BITS   = 32;
  localparam int FRAC         = 16;
  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 100;
  localparam int MAX_REPORTS  = 10;

  // Q16.16 shorthands
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] NEG1 = 32'hFFFF_0000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] TEN  = 32'h000A_0000;
  localparam logic [31:0] HALF_NEG = 32'hFFFF_8000;

  typedef logic signed [127:0] wide_dist_t;
  typedef logic signed [31:0]  coord_t;

  typedef struct {
    cmd_t        cmd;
    logic [2:0]  idx;
    logic [31:0] x, y, z, w, mx, my, mz;
    logic        known;  // expected class typed in below
    cls_t        cls;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  frustum_cull_classifier #(
    .PLANE_COUNT(PLANES),
    .COORD_WIDTH(COORD_BITS),
    .FRAC_BITS  (FRAC)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Plane store as the block should hold it
  coord_t plane_nx  [PLANES];
  coord_t plane_ny  [PLANES];
  coord_t plane_nz  [PLANES];
  coord_t plane_off [PLANES];

  cls_t pending_cls[$];
  int   err_count    = 0;
  int   results_seen = 0;
  int   items_sent   = 0;
  int   send_calm    = 0;
  int   recv_calm    = 0;

  // Directed table: reset planes first, then loads and queries at the extremes
  localparam int DIRECTED_N = 23;
  stim_row_t directed_rows [DIRECTED_N] = '{
    // all planes zero after reset
    '{CMD_POINT,  3'd0, 0, 0, 0, 0, 0, 0, 0, 1'b1, CLS_INSIDE},
    '{CMD_POINT,  3'd7, MAXV, MINV, MAXV, MINV, 0, 0, 0, 1'b1, CLS_INSIDE},
    '{CMD_BOX,    3'd0, MAXV, MAXV, MAXV, 0, MINV, MINV, MINV, 1'b1, CLS_INSIDE},
    '{CMD_SPHERE, 3'd0, 0, 0, 0, 0, 0, 0, 0, 1'b1, CLS_INSIDE},
    '{CMD_SPHERE, 3'd0, 0, 0, 0, ONE, 0, 0, 0, 1'b1, CLS_INTERSECT},
    '{CMD_SPHERE, 3'd0, 0, 0, 0, MINV, 0, 0, 0, 1'b1, CLS_OUTSIDE},
    '{CMD_SPHERE, 3'd3, MINV, MAXV, MINV, MAXV, 0, 0, 0, 1'b1, CLS_INTERSECT},
    // half-space x >= 0; loads to indexes past the last plane are dropped
    '{CMD_LOAD,   3'd0, ONE, 0, 0, 0, 0, 0, 0, 1'b0, CLS_INSIDE},
    '{CMD_LOAD,   3'd6, NEG1, 0, 0, MINV, 0, 0, 0, 1'b0, CLS_INSIDE},
    '{CMD_LOAD,   3'd7, NEG1, MAXV, MINV, MINV, 0, 0, 0, 1'b0, CLS_INSIDE},
    '{CMD_POINT,  3'd0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1'b0, CLS_INSIDE},
    '{CMD_POINT,  3'd0, 0, 0, 0, 0, 0, 0, 0, 1'b0, CLS_INSIDE},
    '{CMD_SPHERE, 3'd0, HALF_NEG, 0, 0, ONE, 0, 0, 0, 1'b0, CLS_INSIDE},
    '{CMD_BOX,    3'd0, NEG1, 0, 0, 0, ONE, ONE, ONE, 1'b0, CLS_INSIDE},
    // y <= 10, then a plane with extreme coefficients
    '{CMD_LOAD,   3'd1, 0, NEG1, 0, TEN, 0, 0, 0, 1'b0, CLS_INSIDE},
    '{CMD_LOAD,   3'd5, MAXV, MINV, MAXV, MINV, 0, 0, 0, 1'b0, CLS_INSIDE},
    '{CMD_POINT,  3'd0, MAXV, MINV, MAXV, 0, 0, 0, 0, 1'b0, CLS_INSIDE},
    '{CMD_SPHERE, 3'd0, MINV, MAXV, MINV, MAXV, 0, 0, 0, 1'b0, CLS_INSIDE},
    '{CMD_BOX,    3'd0, MAXV, MAXV, MAXV, 0, MINV, MINV, MINV, 1'b0, CLS_INSIDE},
    '{CMD_BOX,    3'd0, MINV, MINV, MINV, 0, MAXV, MAXV, MAXV, 1'b0, CLS_INSIDE},
    '{CMD_LOAD,   3'd5, 0, 0, 0, MAXV, 0, 0, 0, 1'b0, CLS_INSIDE},
    '{CMD_LOAD,   3'd2, 0, 0, MINV, MAXV, 0, 0, 0, 1'b0, CLS_INSIDE},
    '{CMD_BOX,    3'd4, ONE, ONE, NEG1, 0, TEN, TEN, ONE, 1'b0, CLS_INSIDE}
  };

  // Exact signed distance, scaled by 2^(2*FRAC)
  function automatic wide_dist_t plane_distance(int p, coord_t px, coord_t py, coord_t pz);
    wide_dist_t d;
    d = wide_dist_t'(plane_nx[p]) * wide_dist_t'(px)
      + wide_dist_t'(plane_ny[p]) * wide_dist_t'(py)
      + wide_dist_t'(plane_nz[p]) * wide_dist_t'(pz)
      + (wide_dist_t'(plane_off[p]) <<< FRAC);
    return d;
  endfunction

  function automatic cls_t classify_query(stim_row_t row);
    cls_t       res;
    wide_dist_t d, r, dn;
    coord_t     lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    res  = CLS_INSIDE;
    r    = wide_dist_t'(coord_t'(row.w)) <<< FRAC;
    for (int p = 0; p < PLANES; p++) begin
      case (row.cmd)
        CMD_POINT: begin
          if (plane_distance(p, row.x, row.y, row.z) < 0) return CLS_OUTSIDE;
        end
        CMD_SPHERE: begin
          d = plane_distance(p, row.x, row.y, row.z);
          if (d + r < 0) return CLS_OUTSIDE;
          if (d - r < 0) res = CLS_INTERSECT;
        end
        default: begin
          // positive corner takes max where the normal component is above zero
          hi_x = (plane_nx[p] > 0) ? row.mx : row.x;
          lo_x = (plane_nx[p] > 0) ? row.x  : row.mx;
          hi_y = (plane_ny[p] > 0) ? row.my : row.y;
          lo_y = (plane_ny[p] > 0) ? row.y  : row.my;
          hi_z = (plane_nz[p] > 0) ? row.mz : row.z;
          lo_z = (plane_nz[p] > 0) ? row.z  : row.mz;
          d  = plane_distance(p, hi_x, hi_y, hi_z);
          dn = plane_distance(p, lo_x, lo_y, lo_z);
          if (d < 0) return CLS_OUTSIDE;
          if (dn < 0) res = CLS_INTERSECT;
        end
      endcase
    end
    return res;
  endfunction

  // Mostly short gaps, a few long ones, and runs with none at all
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] span(int lo, int hi);
    return 32'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  task automatic note_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Offer one item, wait for the transaction, then update the prediction
  task automatic send_item(stim_row_t row);
    int gap;
    gap = pick_gap(send_calm);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tuser  = row.cmd;
    in_tdata  = {5'b0, row.mz, row.my, row.mx, row.w, row.z, row.y, row.x, row.idx};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (row.cmd == CMD_LOAD) begin
      if (row.idx < PLANES) begin
        plane_nx[row.idx]  = row.x;
        plane_ny[row.idx]  = row.y;
        plane_nz[row.idx]  = row.z;
        plane_off[row.idx] = row.w;
        items_sent++;
      end
    end else begin
      pending_cls.push_back(row.known ? row.cls : classify_query(row));
      items_sent++;
    end
  endtask

  function automatic stim_row_t plane_row(int p);
    stim_row_t row;
    row     = '{CMD_LOAD, 3'(p), 0, 0, 0, 0, 0, 0, 0, 1'b0, CLS_INSIDE};
    // zero components now and then exercise the corner choice on equality
    row.x   = ($urandom_range(0, 4) == 0) ? 32'd0 : span(-65536, 65536);
    row.y   = ($urandom_range(0, 4) == 0) ? 32'd0 : span(-65536, 65536);
    row.z   = ($urandom_range(0, 4) == 0) ? 32'd0 : span(-65536, 65536);
    row.w   = span(-64 * 65536, 64 * 65536);
    return row;
  endfunction

  function automatic stim_row_t query_row();
    stim_row_t row;
    row     = '{CMD_POINT, 3'($urandom_range(0, 7)), 0, 0, 0, 0, 0, 0, 0, 1'b0, CLS_INSIDE};
    row.cmd = cmd_t'($urandom_range(1, 3));
    row.x   = span(-96 * 65536, 96 * 65536);
    row.y   = span(-96 * 65536, 96 * 65536);
    row.z   = span(-96 * 65536, 96 * 65536);
    row.w   = span(-2 * 65536, 24 * 65536);
    // box extents may come out negative, i.e. min above max
    row.mx  = row.x + span(-65536, 16 * 65536);
    row.my  = row.y + span(-65536, 16 * 65536);
    row.mz  = row.z + span(-65536, 16 * 65536);
    return row;
  endfunction

  function automatic stim_row_t noise_row();
    stim_row_t row;
    row = '{cmd_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
            $urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), 1'b0, CLS_INSIDE};
    return row;
  endfunction

  // Stimulus and end of run
  initial begin
    int n;
    for (int p = 0; p < PLANES; p++) begin
      plane_nx[p]  = '0;
      plane_ny[p]  = '0;
      plane_nz[p]  = '0;
      plane_off[p] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int k = 0; k < DIRECTED_N; k++) send_item(directed_rows[k]);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        n = $urandom_range(4, 12);
        repeat (n) send_item(noise_row());
      end else begin
        // fresh scene: reload most planes, then query around them
        for (int p = 0; p < PLANES; p++)
          if ($urandom_range(0, 4) != 0) send_item(plane_row(p));
        n = $urandom_range(8, 30);
        repeat (n) send_item(query_row());
      end
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    while (pending_cls.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("frustum_cull_classifier: match");
    end else begin
      $display("frustum_cull_classifier: mismatch");
    end
    $finish;
  end

  // Result side: random back-pressure, one long hold-off, and the checks
  initial begin
    int   hold_left;
    int   pressure_left;
    bit   pressure_done;
    cls_t want;
    hold_left     = 0;
    pressure_left = 0;
    pressure_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (pressure_left > 0) begin
        out_tready = 1'b0;
        pressure_left--;
      end else if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = 1'b1;
        if ($urandom_range(0, 7) == 0) hold_left = pick_gap(recv_calm);
      end
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pending_cls.size() == 0) begin
          note_error($sformatf("result %0d with nothing pending", out_tdata[CLS_W-1:0]));
        end else begin
          want = pending_cls.pop_front();
          if (out_tdata[CLS_W-1:0] !== want)
            note_error($sformatf("classification expected %0d (%s) got %0d",
                                 want, want.name(), out_tdata[CLS_W-1:0]));
        end
        results_seen++;
        if (!pressure_done && results_seen == 250) begin
          pressure_done = 1'b1;
          pressure_left = 400;
        end
      end
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("frustum_cull_classifier: mismatch");
        $finish;
      end
    end
  end

endmodule
